// ----- rtl/core/bilinear_image_resampler_defines.svh -----
// Assertion macros for the bilinear image resampler checker.
// Each macro expects signals named clock and reset in scope.
`ifndef BILINEAR_IMAGE_RESAMPLER_DEFINES_SVH
`define BILINEAR_IMAGE_RESAMPLER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BRS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BRS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/brs_pkg.sv -----
// Shared types and constants of the bilinear image resampler.
// No dependencies.
package brs_pkg;

   localparam int MAX_IN_DIM_DEF  = 128;
   localparam int MAX_OUT_DIM_DEF = 1024;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int FRAC_BITS   = 16;
   localparam int RATIO_W     = 24;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DW      = 11;
   localparam int RSP_LATENCY = 8;

   localparam logic [CSR_IDX_W-1:0] REG_IN_HEIGHT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IN_WIDTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_HEIGHT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_WIDTH  = 2'd3;

   localparam logic REQ_STORE = 1'b0;
   localparam logic REQ_PIXEL = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [9:0]         row;
      logic [9:0]         col;
      logic signed [15:0] sample;
   } brs_req_beat_type;

   typedef struct packed {
      logic signed [15:0] pixel;
      logic [9:0]         pixel_row;
      logic [9:0]         pixel_col;
      logic               coord_error;
   } brs_rsp_beat_type;

endpackage

// ----- rtl/core/bilinear_image_resampler.sv -----
// Bilinear resampler, aligned corners; pixel beats pass the stages to rsp_strobe.
// Throughput one beat per cycle while busy is low; the frame store is split in four
// banks by row and column parity so the four neighbors are read in parallel.
// A size write runs a restoring divider through its load and run states,
// with busy high and csr_ready low. Synchronous reset: sizes 1, ratios 0.
module bilinear_image_resampler #(
   parameter int MAX_IN_DIM  = brs_pkg::MAX_IN_DIM_DEF,
   parameter int MAX_OUT_DIM = brs_pkg::MAX_OUT_DIM_DEF,
   parameter int SAMPLE_BITS = brs_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  brs_pkg::brs_req_beat_type           req_data,
   output logic                                rsp_strobe,
   output brs_pkg::brs_rsp_beat_type           rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [brs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [brs_pkg::CSR_DW-1:0]          csr_wdata
);
   import brs_pkg::*;

   localparam int IW     = $clog2(MAX_IN_DIM + 1);
   localparam int OW     = $clog2(MAX_OUT_DIM + 1);
   localparam int NUM_W  = $clog2(MAX_IN_DIM) + FRAC_BITS + 1;
   localparam int CNT_W  = $clog2(NUM_W + 1);
   localparam int SW     = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
   localparam int HALF   = (MAX_IN_DIM + 1) / 2;
   localparam int BDEPTH = HALF * HALF;
   localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
   localparam int POS_W  = 10 + RATIO_W;

   localparam logic [1:0] DIV_IDLE = 2'd0;
   localparam logic [1:0] DIV_LOAD = 2'd1;
   localparam logic [1:0] DIV_RUN  = 2'd2;

   // ---------------- size registers and ratio divider ----------------
   logic [IW-1:0] ih_ff, iw_ff, ih_in, iw_in;
   logic [OW-1:0] oh_ff, ow_ff, oh_in, ow_in;
   logic [RATIO_W-1:0] row_ratio_ff, col_ratio_ff, row_ratio_in, col_ratio_in;
   logic [1:0] div_state_ff, div_state_in;
   logic [CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [NUM_W-1:0] quo_r_ff, quo_c_ff, quo_r_in, quo_c_in;
   logic [OW:0] rem_r_ff, rem_c_ff, rem_r_in, rem_c_in;
   logic [OW:0] trial_r, trial_c;
   logic [OW-1:0] den_r, den_c;
   logic csr_fire;
   logic [IW-1:0] in_clamp;
   logic [OW-1:0] out_clamp;

   assign busy      = (div_state_ff != DIV_IDLE);
   assign csr_ready = (div_state_ff == DIV_IDLE);
   assign csr_fire  = csr_valid && csr_ready;
   assign den_r     = oh_ff - OW'(1);
   assign den_c     = ow_ff - OW'(1);
   assign trial_r   = {rem_r_ff[OW-1:0], quo_r_ff[NUM_W-1]};
   assign trial_c   = {rem_c_ff[OW-1:0], quo_c_ff[NUM_W-1]};

   always_comb begin
      if (csr_wdata[7:0] == 8'd0) begin
         in_clamp = IW'(1);
      end else if (32'(csr_wdata[7:0]) > MAX_IN_DIM) begin
         in_clamp = IW'(MAX_IN_DIM);
      end else begin
         in_clamp = IW'(csr_wdata[7:0]);
      end
      if (csr_wdata == '0) begin
         out_clamp = OW'(1);
      end else if (32'(csr_wdata) > MAX_OUT_DIM) begin
         out_clamp = OW'(MAX_OUT_DIM);
      end else begin
         out_clamp = OW'(csr_wdata);
      end
   end

   always_comb begin
      ih_in = ih_ff;
      iw_in = iw_ff;
      oh_in = oh_ff;
      ow_in = ow_ff;
      div_state_in = div_state_ff;
      div_cnt_in   = div_cnt_ff;
      quo_r_in = quo_r_ff;
      quo_c_in = quo_c_ff;
      rem_r_in = rem_r_ff;
      rem_c_in = rem_c_ff;
      row_ratio_in = row_ratio_ff;
      col_ratio_in = col_ratio_ff;
      case (div_state_ff)
         DIV_IDLE: begin
            if (csr_fire) begin
               case (csr_index)
                  REG_IN_HEIGHT:  ih_in = in_clamp;
                  REG_IN_WIDTH:   iw_in = in_clamp;
                  REG_OUT_HEIGHT: oh_in = out_clamp;
                  REG_OUT_WIDTH:  ow_in = out_clamp;
                  default: ;
               endcase
               div_state_in = DIV_LOAD;
            end
         end
         DIV_LOAD: begin
            // dividend rounds the quotient up: (in-1)*2^16 + den - 1
            quo_r_in = (NUM_W'(ih_ff - IW'(1)) << FRAC_BITS) + NUM_W'(den_r) - NUM_W'(1);
            quo_c_in = (NUM_W'(iw_ff - IW'(1)) << FRAC_BITS) + NUM_W'(den_c) - NUM_W'(1);
            rem_r_in = '0;
            rem_c_in = '0;
            div_cnt_in = '0;
            div_state_in = DIV_RUN;
         end
         DIV_RUN: begin
            if (trial_r >= {1'b0, den_r}) begin
               rem_r_in = trial_r - {1'b0, den_r};
               quo_r_in = {quo_r_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_r_in = trial_r;
               quo_r_in = {quo_r_ff[NUM_W-2:0], 1'b0};
            end
            if (trial_c >= {1'b0, den_c}) begin
               rem_c_in = trial_c - {1'b0, den_c};
               quo_c_in = {quo_c_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_c_in = trial_c;
               quo_c_in = {quo_c_ff[NUM_W-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + CNT_W'(1);
            if (div_cnt_ff == CNT_W'(NUM_W - 1)) begin
               row_ratio_in = (oh_ff > OW'(1)) ? RATIO_W'(quo_r_in) : '0;
               col_ratio_in = (ow_ff > OW'(1)) ? RATIO_W'(quo_c_in) : '0;
               div_state_in = DIV_IDLE;
            end
         end
         default: div_state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ih_ff <= IW'(1);
         iw_ff <= IW'(1);
         oh_ff <= OW'(1);
         ow_ff <= OW'(1);
         row_ratio_ff <= '0;
         col_ratio_ff <= '0;
         div_state_ff <= DIV_IDLE;
         div_cnt_ff <= '0;
      end else begin
         ih_ff <= ih_in;
         iw_ff <= iw_in;
         oh_ff <= oh_in;
         ow_ff <= ow_in;
         row_ratio_ff <= row_ratio_in;
         col_ratio_ff <= col_ratio_in;
         div_state_ff <= div_state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_r_ff <= quo_r_in;
      quo_c_ff <= quo_c_in;
      rem_r_ff <= rem_r_in;
      rem_c_ff <= rem_c_in;
   end

   // ---------------- stage 1: capture beat, store write, scale ----------------
   logic s1_vld_ff;
   brs_req_beat_type s1_req_ff;
   logic s1_wr, s1_err;
   logic [1:0] s1_wbank;
   logic [BAW-1:0] s1_waddr;
   logic [POS_W-1:0] pos_r, pos_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= req_data;
   end

   assign s1_wr = s1_vld_ff && (s1_req_ff.req_type == REQ_STORE)
                  && (32'(s1_req_ff.row) < 32'(ih_ff)) && (32'(s1_req_ff.col) < 32'(iw_ff));
   assign s1_err = (32'(s1_req_ff.row) >= 32'(oh_ff)) || (32'(s1_req_ff.col) >= 32'(ow_ff));
   assign s1_wbank = {s1_req_ff.row[0], s1_req_ff.col[0]};
   assign s1_waddr = BAW'(32'(s1_req_ff.row[9:1]) * HALF + 32'(s1_req_ff.col[9:1]));
   assign pos_r = POS_W'(s1_req_ff.row) * POS_W'(row_ratio_ff);
   assign pos_c = POS_W'(s1_req_ff.col) * POS_W'(col_ratio_ff);

   // ---------------- stage 2: neighbor indexes and bank addresses ----------------
   logic s2_vld_ff;
   logic s2_err_ff;
   logic [9:0] s2_row_ff, s2_col_ff;
   logic [POS_W-1:0] s2_pos_r_ff, s2_pos_c_ff;
   logic [IW-1:0] y0, y1, x0, x1, y_even, y_odd, x_even, x_odd;
   logic [POS_W-FRAC_BITS-1:0] ipr, ipc;
   logic [BAW-1:0] s2_addr [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff && (s1_req_ff.req_type == REQ_PIXEL);
      end
   end

   always_ff @(posedge clock) begin
      s2_err_ff   <= s1_err;
      s2_row_ff   <= s1_req_ff.row;
      s2_col_ff   <= s1_req_ff.col;
      s2_pos_r_ff <= pos_r;
      s2_pos_c_ff <= pos_c;
   end

   always_comb begin
      ipr = s2_pos_r_ff[POS_W-1:FRAC_BITS];
      ipc = s2_pos_c_ff[POS_W-1:FRAC_BITS];
      y0 = (32'(ipr) > 32'(ih_ff - IW'(1))) ? ih_ff - IW'(1) : IW'(ipr);
      x0 = (32'(ipc) > 32'(iw_ff - IW'(1))) ? iw_ff - IW'(1) : IW'(ipc);
      y1 = (32'(y0) + 1 < 32'(ih_ff)) ? y0 + IW'(1) : y0;
      x1 = (32'(x0) + 1 < 32'(iw_ff)) ? x0 + IW'(1) : x0;
      y_even = y0[0] ? y1 : y0;
      y_odd  = y0[0] ? y0 : y1;
      x_even = x0[0] ? x1 : x0;
      x_odd  = x0[0] ? x0 : x1;
      s2_addr[0] = BAW'(32'(y_even >> 1) * HALF + 32'(x_even >> 1));
      s2_addr[1] = BAW'(32'(y_even >> 1) * HALF + 32'(x_odd >> 1));
      s2_addr[2] = BAW'(32'(y_odd >> 1) * HALF + 32'(x_even >> 1));
      s2_addr[3] = BAW'(32'(y_odd >> 1) * HALF + 32'(x_odd >> 1));
   end

   // ---------------- stage 3: bank reads ----------------
   logic s3_vld_ff, s3_err_ff, s3_yp_ff, s3_xp_ff, s3_ys_ff, s3_xs_ff;
   logic [9:0] s3_row_ff, s3_col_ff;
   logic [FRAC_BITS-1:0] s3_fy_ff, s3_fx_ff;
   logic [BAW-1:0] s3_addr_ff [4];
   logic [SW-1:0] s4_rd_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_err_ff <= s2_err_ff;
      s3_row_ff <= s2_row_ff;
      s3_col_ff <= s2_col_ff;
      s3_yp_ff  <= y0[0];
      s3_xp_ff  <= x0[0];
      s3_ys_ff  <= (y1 == y0);
      s3_xs_ff  <= (x1 == x0);
      s3_fy_ff  <= s2_pos_r_ff[FRAC_BITS-1:0];
      s3_fx_ff  <= s2_pos_c_ff[FRAC_BITS-1:0];
      s3_addr_ff <= s2_addr;
   end

   // bank index is {row parity, column parity}
   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [SW-1:0] bank_mem [BDEPTH];
      always_ff @(posedge clock) begin
         if (s1_wr && (s1_wbank == 2'(b))) begin
            bank_mem[s1_waddr] <= s1_req_ff.sample[SW-1:0];
         end
      end
      always_ff @(posedge clock) begin
         s4_rd_ff[b] <= bank_mem[s3_addr_ff[b]];
      end
   end

   // ---------------- stage 4: select neighbors, column weights ----------------
   logic s4_vld_ff, s4_err_ff, s4_yp_ff, s4_xp_ff, s4_ys_ff, s4_xs_ff;
   logic [9:0] s4_row_ff, s4_col_ff;
   logic [FRAC_BITS-1:0] s4_fy_ff, s4_fx_ff;
   logic yp1, xp1;
   logic signed [15:0] n00, n01, n10, n11;
   logic signed [FRAC_BITS+1:0] wx0, wx1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_err_ff <= s3_err_ff;
      s4_row_ff <= s3_row_ff;
      s4_col_ff <= s3_col_ff;
      s4_yp_ff  <= s3_yp_ff;
      s4_xp_ff  <= s3_xp_ff;
      s4_ys_ff  <= s3_ys_ff;
      s4_xs_ff  <= s3_xs_ff;
      s4_fy_ff  <= s3_fy_ff;
      s4_fx_ff  <= s3_fx_ff;
   end

   always_comb begin
      // a clamped neighbor reuses the base row or column
      yp1 = s4_ys_ff ? s4_yp_ff : !s4_yp_ff;
      xp1 = s4_xs_ff ? s4_xp_ff : !s4_xp_ff;
      n00 = 16'($signed(s4_rd_ff[{s4_yp_ff, s4_xp_ff}]));
      n01 = 16'($signed(s4_rd_ff[{s4_yp_ff, xp1}]));
      n10 = 16'($signed(s4_rd_ff[{yp1, s4_xp_ff}]));
      n11 = 16'($signed(s4_rd_ff[{yp1, xp1}]));
      wx1 = $signed({2'b00, s4_fx_ff});
      wx0 = $signed(18'(1 << FRAC_BITS)) - wx1;
   end

   logic s5_vld_ff, s5_err_ff;
   logic [9:0] s5_row_ff, s5_col_ff;
   logic [FRAC_BITS-1:0] s5_fy_ff;
   logic signed [33:0] p00_ff, p01_ff, p10_ff, p11_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s5_err_ff <= s4_err_ff;
      s5_row_ff <= s4_row_ff;
      s5_col_ff <= s4_col_ff;
      s5_fy_ff  <= s4_fy_ff;
      p00_ff <= wx0 * 34'(n00);
      p01_ff <= wx1 * 34'(n01);
      p10_ff <= wx0 * 34'(n10);
      p11_ff <= wx1 * 34'(n11);
   end

   // ---------------- stage 5: row sums ----------------
   logic s6_vld_ff, s6_err_ff;
   logic [9:0] s6_row_ff, s6_col_ff;
   logic [FRAC_BITS-1:0] s6_fy_ff;
   logic signed [34:0] top_ff, bot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s6_err_ff <= s5_err_ff;
      s6_row_ff <= s5_row_ff;
      s6_col_ff <= s5_col_ff;
      s6_fy_ff  <= s5_fy_ff;
      top_ff <= 35'(p00_ff) + 35'(p01_ff);
      bot_ff <= 35'(p10_ff) + 35'(p11_ff);
   end

   // ---------------- stage 6: row weights ----------------
   logic signed [FRAC_BITS+1:0] wy0, wy1;
   logic s7_vld_ff, s7_err_ff;
   logic [9:0] s7_row_ff, s7_col_ff;
   logic signed [52:0] m0_ff, m1_ff;

   assign wy1 = $signed({2'b00, s6_fy_ff});
   assign wy0 = $signed(18'(1 << FRAC_BITS)) - wy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else begin
         s7_vld_ff <= s6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s7_err_ff <= s6_err_ff;
      s7_row_ff <= s6_row_ff;
      s7_col_ff <= s6_col_ff;
      m0_ff <= 53'(wy0) * 53'(top_ff);
      m1_ff <= 53'(wy1) * 53'(bot_ff);
   end

   // ---------------- stage 7: round and drive the result ----------------
   logic signed [53:0] total;
   assign total = 54'(m0_ff) + 54'(m1_ff) + 54'(64'd1 << 31);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= s7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data.pixel       <= s7_err_ff ? 16'sd0 : $signed(total[47:32]);
      rsp_data.pixel_row   <= s7_row_ff;
      rsp_data.pixel_col   <= s7_col_ff;
      rsp_data.coord_error <= s7_err_ff;
   end

endmodule

// ----- rtl/core/brs_checker.sv -----
// Port-level checker for the bilinear image resampler, bound to the top level.
// Depends on brs_pkg and bilinear_image_resampler_defines.svh.
`include "bilinear_image_resampler_defines.svh"

module brs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input brs_pkg::brs_req_beat_type         req_data,
   input logic                              rsp_strobe,
   input brs_pkg::brs_rsp_beat_type         rsp_data,
   input logic                              csr_valid,
   input logic                              csr_ready
);
   import brs_pkg::*;

   logic pix_beat, store_beat;
   assign pix_beat   = start && !busy && (req_data.req_type == REQ_PIXEL);
   assign store_beat = start && !busy && (req_data.req_type == REQ_STORE);

   `BRS_ASSERT_NEXT(a_csr_busy, csr_valid && csr_ready, busy, "size write did not raise busy")
   `BRS_ASSERT_NOW(a_pix_rsp, pix_beat, ##RSP_LATENCY rsp_strobe, "pixel beat lost")
   `BRS_ASSERT_NOW(a_store_quiet, store_beat, ##RSP_LATENCY !rsp_strobe, "store beat answered")
   `BRS_ASSERT_NOW(a_err_zero, rsp_strobe && rsp_data.coord_error, rsp_data.pixel == 16'sd0,
      "error pixel not zero")

endmodule

bind bilinear_image_resampler brs_checker u_brs_checker (.*);

// ----- test/tb_bilinear_image_resampler.sv -----
// Self-checking bench for bilinear_image_resampler: size writes, plane fills, pixel requests.
// Depends on brs_pkg and the resampler RTL only; expected pixels come from a scoreboard class.
`timescale 1ns / 1ps

module tb_bilinear_image_resampler;
   import brs_pkg::*;

   localparam int STORE_DEPTH = MAX_IN_DIM_DEF * MAX_IN_DIM_DEF;
   localparam int DRAIN_CYCLES = RSP_LATENCY + 4;

   class pixel_scoreboard;
      int unsigned size_reg [4];
      int unsigned row_ratio, col_ratio;
      logic signed [15:0] plane [STORE_DEPTH];
      brs_rsp_beat_type pending_pixels [$];
      int errors, checked;

      function new();
         foreach (size_reg[i]) size_reg[i] = 1;
         row_ratio = 0;
         col_ratio = 0;
         errors = 0;
         checked = 0;
      endfunction

      function int unsigned clamp_dim(int unsigned v, int unsigned maxv);
         if (v == 0) return 1;
         return (v > maxv) ? maxv : v;
      endfunction

      function int unsigned ratio_of(int unsigned in_raw, int unsigned out_raw);
         longint unsigned num, den;
         int unsigned ni, no;
         ni = clamp_dim(in_raw, MAX_IN_DIM_DEF);
         no = clamp_dim(out_raw, MAX_OUT_DIM_DEF);
         if (no <= 1) return 0;
         num = longint'(ni - 1) << FRAC_BITS;
         den = no - 1;
         return int'(((num + den - 1) / den) & 64'hFF_FFFF);
      endfunction

      function void write_size(logic [CSR_IDX_W-1:0] idx, logic [CSR_DW-1:0] data);
         case (idx)
            REG_IN_HEIGHT: size_reg[0] = data[7:0];
            REG_IN_WIDTH: size_reg[1] = data[7:0];
            REG_OUT_HEIGHT: size_reg[2] = data;
            REG_OUT_WIDTH: size_reg[3] = data;
            default: ;
         endcase
         row_ratio = ratio_of(size_reg[0], size_reg[2]);
         col_ratio = ratio_of(size_reg[1], size_reg[3]);
      endfunction

      function void map_coord(int unsigned o, int unsigned ratio, int unsigned n_in,
                              output int unsigned b, output int unsigned nx,
                              output longint f);
         longint unsigned pos;
         pos = longint'(o) * longint'(ratio);
         b = ((pos >> FRAC_BITS) > n_in - 1) ? n_in - 1 : int'(pos >> FRAC_BITS);
         nx = (b + 1 < n_in) ? b + 1 : b;
         f = longint'(pos & 64'hFFFF);
      endfunction

      function longint at(int unsigned r, int unsigned c);
         return longint'(plane[r * MAX_IN_DIM_DEF + c]);
      endfunction

      // Apply one accepted beat: stores update the plane, requests queue a pixel.
      function void note_beat(brs_req_beat_type b);
         int unsigned ih, iw, oh, ow, y0, y1, x0, x1;
         longint fy, fx, top, bot, total, value;
         brs_rsp_beat_type e;
         ih = clamp_dim(size_reg[0], MAX_IN_DIM_DEF);
         iw = clamp_dim(size_reg[1], MAX_IN_DIM_DEF);
         oh = clamp_dim(size_reg[2], MAX_OUT_DIM_DEF);
         ow = clamp_dim(size_reg[3], MAX_OUT_DIM_DEF);
         if (b.req_type == REQ_STORE) begin
            if (b.row < ih && b.col < iw) plane[b.row * MAX_IN_DIM_DEF + b.col] = b.sample;
            return;
         end
         e.pixel_row = b.row;
         e.pixel_col = b.col;
         e.coord_error = 1'b0;
         if (b.row >= oh || b.col >= ow) begin
            e.pixel = '0;
            e.coord_error = 1'b1;
         end else if (ih == oh && iw == ow) begin
            e.pixel = plane[b.row * MAX_IN_DIM_DEF + b.col];
         end else begin
            map_coord(b.row, row_ratio, ih, y0, y1, fy);
            map_coord(b.col, col_ratio, iw, x0, x1, fx);
            top = (65536 - fx) * at(y0, x0) + fx * at(y0, x1);
            bot = (65536 - fx) * at(y1, x0) + fx * at(y1, x1);
            total = (65536 - fy) * top + fy * bot;
            // bias to non-negative so the shift floors, then remove the bias
            value = ((total + 64'sd2147483648 + 64'sd281474976710656) >>> 32) - 65536;
            e.pixel = value[15:0];
         end
         pending_pixels.push_back(e);
      endfunction

      task report(string what);
         $display("MISMATCH @%0t: %s", $realtime, what);
         errors++;
      endtask

      task check_pixel(brs_rsp_beat_type got);
         brs_rsp_beat_type e;
         checked++;
         if (pending_pixels.size() == 0) begin
            report($sformatf("unexpected pixel r%0d c%0d", got.pixel_row, got.pixel_col));
            return;
         end
         e = pending_pixels.pop_front();
         if (got.pixel !== e.pixel)
            report($sformatf("pixel r%0d c%0d: got %0d want %0d",
                             e.pixel_row, e.pixel_col, got.pixel, e.pixel));
         if (got.pixel_row !== e.pixel_row)
            report($sformatf("pixel_row: got %0d want %0d", got.pixel_row, e.pixel_row));
         if (got.pixel_col !== e.pixel_col)
            report($sformatf("pixel_col: got %0d want %0d", got.pixel_col, e.pixel_col));
         if (got.coord_error !== e.coord_error)
            report($sformatf("coord_error r%0d c%0d: got %0b want %0b",
                             e.pixel_row, e.pixel_col, got.coord_error, e.coord_error));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   brs_req_beat_type req_data = '0;
   logic rsp_strobe;
   brs_rsp_beat_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   pixel_scoreboard sb = new();
   int beats_sent = 0;
   int pixels_asked = 0;
   int phases_run = 0;
   bit no_gap = 1'b0;

   bilinear_image_resampler dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_pixel(rsp_data);
   end

   initial begin
      #4_000_000;
      $display("timeout waiting for the resampler");
      $display("DONE: errors detected");
      $finish;
   end

   // Drive one beat; start stays high after acceptance unless a gap follows.
   task send_beat(brs_req_beat_type b);
      if (!no_gap && $urandom_range(99) < 28) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (busy);
      sb.note_beat(b);
      beats_sent++;
      if (b.req_type == REQ_PIXEL) pixels_asked++;
   endtask

   task drain();
      start <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Valid stays high across back-to-back writes; the caller drops it after the last one.
   task write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_size(idx, data);
   endtask

   function logic signed [15:0] pick_sample();
      case ($urandom_range(3))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // One phase: resize, fill the whole input plane, then ask for pixels.
   task run_phase(int unsigned ih_raw, int unsigned iw_raw, int unsigned oh_raw,
                  int unsigned ow_raw, int n_req, bit hold_before_reads);
      int unsigned ih, iw, oh, ow;
      brs_req_beat_type b;
      drain();
      write_csr(REG_IN_HEIGHT, CSR_DW'(ih_raw));
      write_csr(REG_IN_WIDTH, CSR_DW'(iw_raw));
      write_csr(REG_OUT_HEIGHT, CSR_DW'(oh_raw));
      write_csr(REG_OUT_WIDTH, CSR_DW'(ow_raw));
      csr_valid <= 1'b0;
      ih = sb.clamp_dim(sb.size_reg[0], MAX_IN_DIM_DEF);
      iw = sb.clamp_dim(sb.size_reg[1], MAX_IN_DIM_DEF);
      oh = sb.clamp_dim(sb.size_reg[2], MAX_OUT_DIM_DEF);
      ow = sb.clamp_dim(sb.size_reg[3], MAX_OUT_DIM_DEF);
      for (int r = 0; r < ih; r++) begin
         for (int c = 0; c < iw; c++) begin
            if ($urandom_range(9) == 0) begin
               // stray store, dropped by the block when outside the plane
               b.req_type = REQ_STORE;
               b.row = 10'($urandom);
               b.col = 10'($urandom);
               b.sample = 16'($urandom);
               if (b.row >= ih || b.col >= iw) send_beat(b);
            end
            b.req_type = REQ_STORE;
            b.row = 10'(r);
            b.col = 10'(c);
            b.sample = pick_sample();
            send_beat(b);
         end
      end
      if (hold_before_reads) drain();
      for (int k = 0; k < n_req; k++) begin
         b.req_type = REQ_PIXEL;
         b.sample = 16'($urandom);
         if (k == 0) begin
            b.row = 10'd0;
            b.col = 10'd0;
         end else if (k == 1) begin
            b.row = 10'(oh - 1);
            b.col = 10'(ow - 1);
         end else if (k == 2) begin
            b.row = 10'h3FF;
            b.col = 10'h3FF;
         end else if ($urandom_range(99) < 15) begin
            b.row = 10'($urandom);
            b.col = 10'($urandom);
         end else begin
            b.row = 10'($urandom_range(oh - 1));
            b.col = 10'($urandom_range(ow - 1));
         end
         send_beat(b);
      end
      phases_run++;
   endtask

   initial begin
      int unsigned ih, iw;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed corners of the size space
      run_phase(1, 1, 1, 1, 3, 1'b0);
      run_phase(2, 2, 1024, 1024, 4, 1'b0);
      run_phase(128, 2, 1024, 3, 4, 1'b1);
      run_phase(3, 128, 5, 1024, 4, 1'b0);
      run_phase(0, 3, 0, 7, 4, 1'b0);
      run_phase(255, 2, 2047, 4, 4, 1'b0);
      run_phase(5, 7, 5, 7, 4, 1'b0);
      run_phase(9, 12, 4, 5, 4, 1'b0);
      while (beats_sent < 2000) begin
         no_gap = (phases_run % 7 == 3);
         if ($urandom_range(9) == 0) begin
            ih = $urandom_range(1, 128);
            iw = $urandom_range(1, 3);
         end else begin
            ih = $urandom_range(1, 10);
            iw = $urandom_range(1, 10);
         end
         case ($urandom_range(4))
            0: run_phase(ih, iw, ih, iw, 60, 1'b0);
            1: run_phase(ih, iw, $urandom_range(1, 1024), $urandom_range(1, 1024), 60, 1'b0);
            2: run_phase(ih, iw, $urandom_range(0, 2047), $urandom_range(0, 2047), 40, 1'b0);
            default: run_phase(ih, iw, $urandom_range(1, 40), $urandom_range(1, 40), 60,
                               $urandom_range(3) == 0);
         endcase
      end
      drain();
      sb.errors += sb.pending_pixels.size();
      $display("covered %0d size settings, %0d beats, %0d pixel requests, %0d pixels checked",
               phases_run, beats_sent, pixels_asked, sb.checked);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
